[sv/ssg_pkg.sv]
// Package: shared types and constants for the GF(256) Shamir share splitter.
`timescale 1ns / 1ps

package ssg_pkg;

    localparam int NUM_COEF_FIELDS = 7;
    localparam logic [7:0] GF_POLY_LOW = 8'h1B;  // x^8 + x^4 + x^3 + x + 1, low byte

    localparam int TOTAL_W   = 5;
    localparam int THRESH_W  = 4;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [TOTAL_W-1:0]  TOTAL_RESET  = 5'd5;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd2;

    typedef logic [7:0] t_byte;

    typedef enum logic {
        REG_TOTAL_SHARES = 1'b0,
        REG_THRESHOLD    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total_shares;
        logic [THRESH_W-1:0] threshold;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

endpackage

[sv/ssg_if.sv]
// Interfaces: input byte request channel and share result channel.
`timescale 1ns / 1ps

interface ssg_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  secret_byte;
    logic [7:0]  coef_deg1;
    logic [7:0]  coef_deg2;
    logic [7:0]  coef_deg3;
    logic [7:0]  coef_deg4;
    logic [7:0]  coef_deg5;
    logic [7:0]  coef_deg6;
    logic [7:0]  coef_deg7;
    logic        secret_end;

    modport source (
        output valid, secret_byte, coef_deg1, coef_deg2, coef_deg3, coef_deg4,
               coef_deg5, coef_deg6, coef_deg7, secret_end,
        input  ready
    );
    modport sink (
        input  valid, secret_byte, coef_deg1, coef_deg2, coef_deg3, coef_deg4,
               coef_deg5, coef_deg6, coef_deg7, secret_end,
        output ready
    );
endinterface

interface ssg_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  share_byte;
    logic [4:0]  share_x;
    logic        last_share;
    logic        secret_done;

    modport source (
        output valid, share_byte, share_x, last_share, secret_done,
        input  ready
    );
    modport sink (
        input  valid, share_byte, share_x, last_share, secret_done,
        output ready
    );
endinterface

[sv/ssg_gf_mul.sv]
// GF(256) multiplier in the AES field, shift-and-add over the eight bits of b.
`timescale 1ns / 1ps

module ssg_gf_mul (
    input  ssg_pkg::t_byte i_a,
    input  ssg_pkg::t_byte i_b,
    output ssg_pkg::t_byte o_p
);

    always_comb begin
        ssg_pkg::t_byte acc;
        ssg_pkg::t_byte a;
        acc = '0;
        a   = i_a;
        for (int i = 0; i < 8; i++) begin
            if (i_b[i]) begin
                acc = acc ^ a;
            end
            a = a[7] ? ((a << 1) ^ ssg_pkg::GF_POLY_LOW) : (a << 1);
        end
        o_p = acc;
    end

endmodule

[sv/ssg_apb_regs.sv]
// APB register block: share count and threshold.
`timescale 1ns / 1ps

module ssg_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssg_pkg::ADDR_W-1:0]    paddr,
    input  logic [ssg_pkg::DATA_W-1:0]    pwdata,
    output logic [ssg_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output ssg_pkg::t_cfg                 o_cfg
);

    ssg_pkg::t_cfg     r_cfg;
    ssg_pkg::t_cfg     n_cfg;
    ssg_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    // word select; byte offset bits are ignored
    assign w_idx  = ssg_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                ssg_pkg::REG_TOTAL_SHARES: n_cfg.total_shares = pwdata[ssg_pkg::TOTAL_W-1:0];
                ssg_pkg::REG_THRESHOLD:    n_cfg.threshold    = pwdata[ssg_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ssg_pkg::REG_TOTAL_SHARES:
                prdata = {{(ssg_pkg::DATA_W-ssg_pkg::TOTAL_W){1'b0}}, r_cfg.total_shares};
            ssg_pkg::REG_THRESHOLD:
                prdata = {{(ssg_pkg::DATA_W-ssg_pkg::THRESH_W){1'b0}}, r_cfg.threshold};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_shares <= ssg_pkg::TOTAL_RESET;
            r_cfg.threshold    <= ssg_pkg::THRESH_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/shamir_gf256_share_split.sv]
// Shamir share splitter over GF(256): one secret byte in, one share out per x = 1..N.
// Each accepted byte is evaluated by Horner's rule on a single shared GF(256)
// multiplier, one coefficient per cycle. A share takes degree multiply steps
// (degree = threshold - 1, capped at MAX_COEFFS), then the emit state hands it
// to the output register, waiting while that register is full, and restarts
// for the next x. N = total_shares, capped at MAX_SHARES; a share count of
// zero yields no shares and drops the byte's end mark. The input is not ready
// while a byte is being worked on; the output register lets the next share's
// multiply steps proceed while a share waits to be taken. Registers:
// total_shares at byte address 0, threshold at byte address 4. The user must
// write them only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module shamir_gf256_share_split #(
    parameter int MAX_COEFFS = 7,
    parameter int MAX_SHARES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ssg_in_if.sink                        i_in,
    ssg_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssg_pkg::ADDR_W-1:0]    paddr,
    input  logic [ssg_pkg::DATA_W-1:0]    pwdata,
    output logic [ssg_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int KW = $clog2(MAX_COEFFS + 1);
    localparam int CW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int SW = ssg_pkg::TOTAL_W;
    localparam int CMPW = (SW > $clog2(MAX_SHARES + 1)) ? SW : $clog2(MAX_SHARES + 1);

    ssg_pkg::t_cfg   w_cfg;

    ssg_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // request payload latched on accept
    ssg_pkg::t_byte  r_secret;
    ssg_pkg::t_byte  r_coef [MAX_COEFFS];
    logic            r_end;
    ssg_pkg::t_byte  w_field [ssg_pkg::NUM_COEF_FIELDS];

    // sequencer
    ssg_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_shares, n_shares;
    logic [KW-1:0]   r_degree, n_degree;
    logic [SW-1:0]   r_x, n_x;
    logic [KW-1:0]   r_k, n_k;
    ssg_pkg::t_byte  r_acc, n_acc;

    // output register
    logic            r_ov, n_ov;
    ssg_pkg::t_byte  r_share_byte, n_share_byte;
    logic [SW-1:0]   r_share_x, n_share_x;
    logic            r_last, n_last;
    logic            r_done, n_done;

    logic            w_accept;
    logic            w_out_free;
    logic            w_is_last;
    logic [SW-1:0]   w_shares;
    logic [ssg_pkg::THRESH_W-1:0] w_deg_raw;
    logic [KW-1:0]   w_degree;
    logic [CW-1:0]   w_cidx;
    ssg_pkg::t_byte  w_mul_a;
    ssg_pkg::t_byte  w_mul_b;
    ssg_pkg::t_byte  w_mul_p;

    assign w_field[0] = i_in.coef_deg1;
    assign w_field[1] = i_in.coef_deg2;
    assign w_field[2] = i_in.coef_deg3;
    assign w_field[3] = i_in.coef_deg4;
    assign w_field[4] = i_in.coef_deg5;
    assign w_field[5] = i_in.coef_deg6;
    assign w_field[6] = i_in.coef_deg7;

    assign i_in.ready = (r_state == ssg_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // saturate share count and degree
    assign w_shares  = (CMPW'(w_cfg.total_shares) > CMPW'(MAX_SHARES))
                     ? SW'(MAX_SHARES) : w_cfg.total_shares;
    assign w_deg_raw = (w_cfg.threshold == '0) ? '0 : w_cfg.threshold - 1'b1;
    assign w_degree  = (w_deg_raw > ssg_pkg::THRESH_W'(MAX_COEFFS))
                     ? KW'(MAX_COEFFS) : KW'(w_deg_raw);

    // Horner step: acc <- (acc ^ c[k-1]) * x
    assign w_cidx  = CW'(r_k - KW'(1));
    assign w_mul_a = r_acc ^ r_coef[w_cidx];
    assign w_mul_b = 8'(r_x);

    ssg_gf_mul u_mul (
        .i_a (w_mul_a),
        .i_b (w_mul_b),
        .o_p (w_mul_p)
    );

    assign w_out_free = !r_ov || o_out.ready;
    assign w_is_last  = (r_x == r_shares);

    always_comb begin
        n_state      = r_state;
        n_shares     = r_shares;
        n_degree     = r_degree;
        n_x          = r_x;
        n_k          = r_k;
        n_acc        = r_acc;
        n_ov         = r_ov;
        n_share_byte = r_share_byte;
        n_share_x    = r_share_x;
        n_last       = r_last;
        n_done       = r_done;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ssg_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_shares = w_shares;
                    n_degree = w_degree;
                    n_x      = SW'(1);
                    n_k      = w_degree;
                    n_acc    = '0;
                    if (w_shares != '0) begin
                        n_state = ssg_pkg::S_CALC;
                    end
                end
            end
            ssg_pkg::S_CALC: begin
                if (r_k == '0) begin
                    n_state = ssg_pkg::S_EMIT;
                end else begin
                    n_acc = w_mul_p;
                    n_k   = r_k - KW'(1);
                end
            end
            ssg_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_ov         = 1'b1;
                    n_share_byte = r_acc ^ r_secret;
                    n_share_x    = r_x;
                    n_last       = w_is_last;
                    n_done       = w_is_last && r_end;
                    if (w_is_last) begin
                        n_state = ssg_pkg::S_IDLE;
                    end else begin
                        n_x     = r_x + SW'(1);
                        n_k     = r_degree;
                        n_acc   = '0;
                        n_state = ssg_pkg::S_CALC;
                    end
                end
            end
            default: begin
                n_state = ssg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssg_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shares     <= n_shares;
        r_degree     <= n_degree;
        r_x          <= n_x;
        r_k          <= n_k;
        r_acc        <= n_acc;
        r_share_byte <= n_share_byte;
        r_share_x    <= n_share_x;
        r_last       <= n_last;
        r_done       <= n_done;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_secret <= i_in.secret_byte;
            r_end    <= i_in.secret_end;
        end
    end

    // degrees beyond the input fields read as zero
    for (genvar g = 0; g < MAX_COEFFS; g++) begin : g_coef
        always_ff @(posedge i_clk) begin
            if (w_accept) begin
                if (g < ssg_pkg::NUM_COEF_FIELDS) begin
                    r_coef[g] <= w_field[g % ssg_pkg::NUM_COEF_FIELDS];
                end else begin
                    r_coef[g] <= '0;
                end
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.share_byte  = r_share_byte;
    assign o_out.share_x     = r_share_x;
    assign o_out.last_share  = r_last;
    assign o_out.secret_done = r_done;

endmodule
